// ===== sv/srl_pkg.sv =====
// Package for the sorted record list: record and result types, operation and
// status codes, and the default list depth. Used by every module of the block.
// No dependencies.
package srl_pkg;

    localparam int LIST_DEPTH_DEF = 64;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_REMOVE_MAX = 3'd1;
    localparam logic [2:0] OP_REMOVE_ID  = 3'd2;
    localparam logic [2:0] OP_FIND_ID    = 3'd3;
    localparam logic [2:0] OP_PEEK_MAX   = 3'd4;
    localparam logic [2:0] OP_PEEK_MIN   = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] amount;
        logic [31:0] id;
    } rec_t;

    typedef struct packed {
        logic [6:0]  entry_count;
        logic [31:0] rec_amount;
        logic [31:0] rec_id;
        logic [1:0]  status;
    } res_t;

endpackage

// ===== sv/srl_ram.sv =====
// Record store of the sorted record list: one write port and one registered
// read port. Depends on srl_pkg for the record type.
module srl_ram #(
    parameter int DEPTH = srl_pkg::LIST_DEPTH_DEF,
    parameter int AW    = $clog2(srl_pkg::LIST_DEPTH_DEF)
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  srl_pkg::rec_t   wdata,
    input  logic [AW-1:0]   raddr,
    output srl_pkg::rec_t   rdata
);

    srl_pkg::rec_t mem [DEPTH];
    srl_pkg::rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/srl_ctrl.sv =====
// Sequencer of the sorted record list: walks the record store one entry at a time,
// with a read state and a compare state per entry, to insert, search and shift.
// Depends on srl_pkg; drives the ports of srl_ram.
module srl_ctrl #(
    parameter int LIST_DEPTH = srl_pkg::LIST_DEPTH_DEF,
    parameter int AW         = $clog2(srl_pkg::LIST_DEPTH_DEF)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2:0]      in_op,
    input  logic [31:0]     in_amount,
    input  logic [31:0]     in_key,
    input  logic            out_free,
    output logic            res_valid,
    output srl_pkg::res_t   res,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output srl_pkg::rec_t   mem_wdata,
    output logic [AW-1:0]   mem_raddr,
    input  srl_pkg::rec_t   mem_rdata
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_RD   = 8'b0000_0010,
        S_INS_CMP  = 8'b0000_0100,
        S_SRCH_RD  = 8'b0000_1000,
        S_SRCH_CMP = 8'b0001_0000,
        S_END_RD   = 8'b0010_0000,
        S_END_CMP  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   serial_reg, serial_next;
    logic          found_reg, found_next;
    logic [2:0]    op_reg, op_next;
    logic [31:0]   amt_reg, amt_next;
    logic [31:0]   key_reg, key_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   rid_reg, rid_next;
    logic [31:0]   ramt_reg, ramt_next;
    logic [CW-1:0] idx_dec;
    logic          amt_greater;
    logic          id_match;

    assign idx_dec     = idx_reg - CW'(1);
    assign amt_greater = mem_rdata.amount > amt_reg;
    assign id_match    = mem_rdata.id == key_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        serial_next = serial_reg;
        found_next  = found_reg;
        op_next     = op_reg;
        amt_next    = amt_reg;
        key_next    = key_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        ramt_next   = ramt_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg[AW-1:0];
        res_valid   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_op;
                    amt_next    = in_amount;
                    key_next    = in_key;
                    status_next = srl_pkg::ST_OK;
                    rid_next    = '0;
                    ramt_next   = '0;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    state_next  = S_DONE;
                    unique case (in_op)
                        srl_pkg::OP_INSERT: begin
                            if (count_reg == CW'(LIST_DEPTH)) begin
                                status_next = srl_pkg::ST_FULL;
                            end else begin
                                serial_next = serial_reg + 32'd1;
                                rid_next    = serial_reg + 32'd1;
                                ramt_next   = in_amount;
                                idx_next    = count_reg;
                                state_next  = S_INS_RD;
                            end
                        end
                        srl_pkg::OP_REMOVE_MAX, srl_pkg::OP_PEEK_MAX: begin
                            if (count_reg == '0) begin
                                status_next = srl_pkg::ST_MISS;
                            end else begin
                                idx_next   = count_reg - CW'(1);
                                state_next = S_END_RD;
                            end
                        end
                        srl_pkg::OP_PEEK_MIN: begin
                            if (count_reg == '0) begin
                                status_next = srl_pkg::ST_MISS;
                            end else begin
                                state_next = S_END_RD;
                            end
                        end
                        srl_pkg::OP_REMOVE_ID, srl_pkg::OP_FIND_ID: begin
                            state_next = S_SRCH_RD;
                        end
                        srl_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{amount: amt_reg, id: rid_reg};
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end else begin
                    mem_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (amt_greater) begin
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end else begin
                    mem_wdata  = '{amount: amt_reg, id: rid_reg};
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SRCH_RD: begin
                if (idx_reg == count_reg) begin
                    if (!found_reg) begin
                        status_next = srl_pkg::ST_MISS;
                    end else if (op_reg == srl_pkg::OP_REMOVE_ID) begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_DONE;
                end else begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_SRCH_RD;
                if (found_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_dec[AW-1:0];
                end else if (id_match) begin
                    found_next = 1'b1;
                    rid_next   = mem_rdata.id;
                    ramt_next  = mem_rdata.amount;
                    if (op_reg == srl_pkg::OP_FIND_ID) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_END_RD: begin
                state_next = S_END_CMP;
            end
            S_END_CMP: begin
                rid_next  = mem_rdata.id;
                ramt_next = mem_rdata.amount;
                if (op_reg == srl_pkg::OP_REMOVE_MAX) begin
                    count_next = count_reg - CW'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            serial_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            serial_reg <= serial_next;
        end
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        op_reg     <= op_next;
        amt_reg    <= amt_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        ramt_reg   <= ramt_next;
    end

    assign in_ready        = state_reg == S_IDLE;
    assign res.status      = status_reg;
    assign res.rec_id      = rid_reg;
    assign res.rec_amount  = ramt_reg;
    assign res.entry_count = 7'(count_reg);

endmodule

// ===== sv/sorted_record_list.sv =====
// Top level of the sorted record list: stream ports, result register, the
// sequencer and the record store. Depends on srl_pkg, srl_ram and srl_ctrl.
//
//   Channel   Direction  Fields (tdata, lowest bit first)
//   s_        in         op[2:0], amount[34:3], key_id[66:35], zero to 72 bits
//   m_        out        status[1:0], rec_id[33:2], rec_amount[65:34],
//                        entry_count[72:66], zero to 80 bits
//
// Clear, a rejected insert or an unused code finishes without using the record store.
// The peeks and remove max read one entry. Insert walks the entries above the
// new one. Find by ID walks the entries up to the match; remove by ID or a
// failed search walks every held entry. The walk reads each entry of the
// record store through its registered read port and then compares it.
// After reset the list is empty and the ID counter is 0.
// A new command is taken while a result waits in the output register; its
// result is held back until that transfer completes.
module sorted_record_list #(
    parameter int LIST_DEPTH = srl_pkg::LIST_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op, amount, key_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status, rec_id, rec_amount, entry_count
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic            out_free;
    logic            res_valid;
    srl_pkg::res_t   res;
    srl_pkg::res_t   m_data_reg;
    logic            m_tvalid_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    srl_pkg::rec_t   mem_wdata;
    logic [AW-1:0]   mem_raddr;
    srl_pkg::rec_t   mem_rdata;

    assign out_free = !m_tvalid_reg || m_tready;

    srl_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[2:0]),
        .in_amount (s_tdata[34:3]),
        .in_key    (s_tdata[66:35]),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    srl_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_tvalid || m_tready))
        else $error("result produced while the output register is still full");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer ready again straight after taking a command");

    a_full_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == srl_pkg::ST_FULL) |-> (res.rec_id == 32'd0))
        else $error("rejected insert carries a record ID");

endmodule

// ===== tb/sv/record_list_checker.sv =====
// Checker for the sorted record list: watches both stream channels, keeps its
// own copy of the list to predict each result, and compares every result transfer.
// Depends on srl_pkg.
module record_list_checker #(
    parameter int DEPTH = srl_pkg::LIST_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    output int          mismatch_count,
    output int          results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]   list_amount [DEPTH];
    logic [31:0]   list_id [DEPTH];
    int            list_held = 0;
    logic [31:0]   id_serial = '0;
    srl_pkg::res_t expected_results [$];
    int            fails = 0;

    function automatic srl_pkg::res_t apply_list_op(logic [2:0] op, logic [31:0] amount,
                                                    logic [31:0] key);
        srl_pkg::res_t r;
        int            pos;
        bit            hit;
        r   = '0;
        pos = 0;
        hit = 1'b0;
        case (op)
            srl_pkg::OP_INSERT: begin
                if (list_held >= DEPTH) begin
                    r.status = srl_pkg::ST_FULL;
                end else begin
                    while (pos < list_held && list_amount[pos] <= amount) pos++;
                    for (int i = list_held; i > pos; i--) begin
                        list_amount[i] = list_amount[i-1];
                        list_id[i]     = list_id[i-1];
                    end
                    id_serial         = id_serial + 32'd1;
                    list_amount[pos]  = amount;
                    list_id[pos]      = id_serial;
                    list_held++;
                    r.rec_id     = id_serial;
                    r.rec_amount = amount;
                end
            end
            srl_pkg::OP_REMOVE_MAX, srl_pkg::OP_PEEK_MAX: begin
                if (list_held == 0) begin
                    r.status = srl_pkg::ST_MISS;
                end else begin
                    r.rec_id     = list_id[list_held-1];
                    r.rec_amount = list_amount[list_held-1];
                    if (op == srl_pkg::OP_REMOVE_MAX) list_held--;
                end
            end
            srl_pkg::OP_REMOVE_ID, srl_pkg::OP_FIND_ID: begin
                for (int i = 0; i < list_held; i++) begin
                    if (!hit && list_id[i] == key) begin
                        hit = 1'b1;
                        pos = i;
                    end
                end
                if (!hit) begin
                    r.status = srl_pkg::ST_MISS;
                end else begin
                    r.rec_id     = list_id[pos];
                    r.rec_amount = list_amount[pos];
                    if (op == srl_pkg::OP_REMOVE_ID) begin
                        for (int i = pos; i + 1 < list_held; i++) begin
                            list_amount[i] = list_amount[i+1];
                            list_id[i]     = list_id[i+1];
                        end
                        list_held--;
                    end
                end
            end
            srl_pkg::OP_PEEK_MIN: begin
                if (list_held == 0) begin
                    r.status = srl_pkg::ST_MISS;
                end else begin
                    r.rec_id     = list_id[0];
                    r.rec_amount = list_amount[0];
                end
            end
            srl_pkg::OP_CLEAR: begin
                list_held = 0;
            end
            default: begin
            end
        endcase
        r.entry_count = 7'(list_held);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        srl_pkg::res_t got;
        srl_pkg::res_t want;
        if (!aresetn) begin
            list_held = 0;
            id_serial = '0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[72:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: expected no result, actual %0h", $time, got);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("rec_id", want.rec_id, got.rec_id);
                    check_field("rec_amount", want.rec_amount, got.rec_amount);
                    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_list_op(s_tdata[2:0], s_tdata[34:3],
                                                         s_tdata[66:35]));
        end
        mismatch_count  <= fails;
        results_pending <= expected_results.size();
    end

endmodule

// ===== tb/sv/sorted_record_list_tb.sv =====
// Top of the sorted record list testbench: clock, reset, command stimulus and
// result back-pressure, and the verdict. Depends on srl_pkg, sorted_record_list
// and record_list_checker.
module sorted_record_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  OP_SPARE    = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int          DRAIN_WAIT  = 300;

    typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} load_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        calm_stretch = 1'b0;
    int          mismatch_count;
    int          results_pending;
    int unsigned inserts_issued = 0;
    int unsigned cycle_count = 0;

    always #5ns aclk = ~aclk;

    sorted_record_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    record_list_checker list_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always @(posedge aclk) begin
        m_tready <= calm_stretch || ($urandom_range(99) >= 36);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic issue_command(input logic [2:0] op, input logic [31:0] amount,
                                 input logic [31:0] key);
        while (!calm_stretch && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, key, amount, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == srl_pkg::OP_INSERT) inserts_issued++;
    endtask

    function automatic logic [31:0] pick_amount();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return 32'($urandom_range(7) * 100);
        if (r < 45) return 32'h0;
        if (r < 50) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75 && inserts_issued > 0)
            return inserts_issued
                   - $urandom_range(inserts_issued > 80 ? 80 : inserts_issued - 1);
        if (r < 80) return 32'h0;
        if (r < 85) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_op(load_mode_t mode);
        int unsigned r;
        int unsigned insert_pct;
        int unsigned clear_pct;
        r          = $urandom_range(99);
        insert_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 15 : 45;
        clear_pct  = (mode == MODE_FILL) ? 0 : (mode == MODE_DRAIN) ? 2 : 3;
        if (r < clear_pct) return srl_pkg::OP_CLEAR;
        if (r == clear_pct) return OP_SPARE;
        if (r < clear_pct + 1 + insert_pct) return srl_pkg::OP_INSERT;
        case ($urandom_range(9))
            0, 1, 2: return srl_pkg::OP_REMOVE_ID;
            3, 4:    return srl_pkg::OP_FIND_ID;
            5, 6:    return srl_pkg::OP_REMOVE_MAX;
            7:       return srl_pkg::OP_PEEK_MAX;
            8:       return srl_pkg::OP_PEEK_MIN;
            default: return srl_pkg::OP_FIND_ID;
        endcase
    endfunction

    initial begin
        load_mode_t mode;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue_command(srl_pkg::OP_PEEK_MAX, $urandom(), $urandom());
        issue_command(srl_pkg::OP_PEEK_MIN, $urandom(), $urandom());
        issue_command(srl_pkg::OP_REMOVE_MAX, $urandom(), $urandom());
        issue_command(srl_pkg::OP_FIND_ID, $urandom(), 32'h0);
        issue_command(srl_pkg::OP_REMOVE_ID, $urandom(), 32'd1);
        issue_command(srl_pkg::OP_INSERT, 32'h0, $urandom());
        issue_command(srl_pkg::OP_INSERT, 32'hFFFF_FFFF, $urandom());
        issue_command(srl_pkg::OP_INSERT, 32'd500, $urandom());
        issue_command(srl_pkg::OP_INSERT, 32'd500, $urandom());
        issue_command(srl_pkg::OP_INSERT, 32'd500, $urandom());
        issue_command(srl_pkg::OP_FIND_ID, $urandom(), 32'd4);
        issue_command(srl_pkg::OP_PEEK_MIN, $urandom(), $urandom());
        issue_command(srl_pkg::OP_PEEK_MAX, $urandom(), $urandom());
        issue_command(srl_pkg::OP_REMOVE_ID, $urandom(), 32'd4);
        issue_command(srl_pkg::OP_REMOVE_ID, $urandom(), 32'd1);
        issue_command(srl_pkg::OP_FIND_ID, $urandom(), 32'd4);
        issue_command(srl_pkg::OP_REMOVE_MAX, $urandom(), $urandom());
        issue_command(OP_SPARE, $urandom(), $urandom());
        issue_command(srl_pkg::OP_FIND_ID, $urandom(), 32'hFFFF_FFFF);
        issue_command(srl_pkg::OP_CLEAR, $urandom(), $urandom());
        issue_command(srl_pkg::OP_PEEK_MIN, $urandom(), $urandom());
        issue_command(srl_pkg::OP_INSERT, 32'd7, $urandom());
        issue_command(srl_pkg::OP_FIND_ID, $urandom(), 32'd6);
        issue_command(srl_pkg::OP_REMOVE_ID, $urandom(), 32'd6);

        for (int blk = 0; blk < 10; blk++) begin
            case (blk)
                0, 3:    mode = MODE_FILL;
                1:       mode = MODE_DRAIN;
                default: mode = load_mode_t'($urandom_range(2));
            endcase
            calm_stretch <= (blk == 4);
            for (int n = 0; n < 100; n++)
                issue_command(pick_op(mode), pick_amount(), pick_key());
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
